FILE: hw/rtl/kwm_pkg.sv
// Shared types, constants and helper functions for the k-way merge min-queue.
// Used by kwm_ram, kwm_minscan and kway_merge_min_heap_core; depends on nothing.
package kwm_pkg;

  localparam int NUM_SOURCES   = 8;
  localparam int VALUE_WIDTH   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int TAG_W         = 3;
  localparam int OCC_W         = 4;
  localparam int STATUS_W      = 2;
  localparam int IDX_W         = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CNT_W         = $clog2(NUM_SOURCES + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_SOURCES);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [TAG_W-1:0]              tag;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic [IDX_W-1:0] idx;
  } scan_feed_t;

  function automatic logic [VALUE_WIDTH-1:0] field_to_value(
      input logic [VALUE_FIELD_W-1:0] v);
    logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] wide;
    wide = {{VALUE_WIDTH{1'b0}}, v};
    return wide[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_FIELD_W-1:0] value_to_field(
      input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] wide;
    wide = {{VALUE_FIELD_W{1'b0}}, v};
    return wide[VALUE_FIELD_W-1:0];
  endfunction

  // True when entry a must leave before entry b.
  function automatic logic leaves_first(input entry_t a, input entry_t b);
    logic result;
    if (a.value != b.value) begin
      result = $signed(a.value) < $signed(b.value);
    end else begin
      result = a.tag < b.tag;
    end
    return result;
  endfunction

endpackage

FILE: hw/rtl/kwm_ram.sv
// Entry store of the merge queue: one write port, one read port, registered read.
// Depends on kwm_pkg for the entry type and depth.
module kwm_ram (
  input  logic                  clk,
  input  logic                  we,
  input  logic [kwm_pkg::IDX_W-1:0] waddr,
  input  kwm_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [kwm_pkg::IDX_W-1:0] raddr,
  output kwm_pkg::entry_t       rdata
);

  kwm_pkg::entry_t mem [kwm_pkg::NUM_SOURCES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/kwm_minscan.sv
// Running minimum over entries read out of the store, one entry per cycle.
// Depends on kwm_pkg for the entry type, feed struct and ordering function.
module kwm_minscan (
  input  logic                      clk,
  input  kwm_pkg::scan_feed_t       feed,
  input  kwm_pkg::entry_t           data,
  output kwm_pkg::entry_t           best_entry,
  output logic [kwm_pkg::IDX_W-1:0] best_idx
);

  always_ff @(posedge clk) begin
    if (feed.valid) begin
      if (feed.first || kwm_pkg::leaves_first(data, best_entry)) begin
        best_entry <= data;
        best_idx   <= feed.idx;
      end
    end
  end

endmodule

FILE: hw/rtl/kway_merge_min_heap_core.sv
// Top level of the k-way merge min-queue: command handshake, sequencer, result register.
// Depends on kwm_pkg, kwm_ram and kwm_minscan.
//
// The queue holds up to NUM_SOURCES tagged signed values in a single-port-read memory.
// An insert, an insert into a full queue and a pop from an empty queue finish in the
// cycle the command word is taken. A pop from a queue holding N entries reads the N
// entries one per cycle through the memory's read port, then passes the tail and finish
// states, and its result word is loaded once the output register is free.
// Equal values leave in order of ascending source number. A result word waits in an
// output register, so a new command may be taken in the same cycle that the previous
// result word is taken.
module kway_merge_min_heap_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic        command,
  input  logic [2:0]  source_id,
  input  logic signed [31:0] value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]  out_source,
  output logic [1:0]  status,
  output logic        not_empty,
  output logic [3:0]  occupancy
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state, state_next;
  logic [kwm_pkg::CNT_W-1:0] count, count_next, count_m1;
  logic [kwm_pkg::IDX_W-1:0] scan_idx, scan_idx_next, last_idx;
  kwm_pkg::scan_feed_t feed, feed_next;

  logic slot_free, accept, is_pop, full, finish, load;
  logic ram_we, ram_re;
  logic [kwm_pkg::IDX_W-1:0] ram_waddr;
  kwm_pkg::entry_t ram_wdata, ram_rdata, new_entry, best_entry;
  logic [kwm_pkg::IDX_W-1:0] best_idx;

  logic [31:0] value_next;
  logic [2:0]  source_next;
  logic [1:0]  status_next;
  logic [kwm_pkg::CNT_W+kwm_pkg::OCC_W-1:0] occ_wide;

  kwm_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  kwm_minscan u_minscan (
    .clk        (clk),
    .feed       (feed),
    .data       (ram_rdata),
    .best_entry (best_entry),
    .best_idx   (best_idx)
  );

  assign slot_free = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && slot_free;
  assign accept    = cmd_valid && cmd_ready;
  assign is_pop    = (command == kwm_pkg::CMD_POP);
  assign full      = (count >= kwm_pkg::FULL_COUNT);
  assign finish    = (state == S_FINISH) && slot_free;
  assign count_m1  = count - 1'b1;
  assign last_idx  = count_m1[kwm_pkg::IDX_W-1:0];

  assign new_entry.value = kwm_pkg::field_to_value(value);
  assign new_entry.tag   = source_id;

  assign ram_we    = (accept && !is_pop && !full) || finish;
  assign ram_waddr = finish ? best_idx : count[kwm_pkg::IDX_W-1:0];
  assign ram_wdata = finish ? ram_rdata : new_entry;
  assign ram_re    = (state == S_SCAN);

  assign load = (accept && (!is_pop || (count == '0))) || finish;

  always_comb begin
    state_next     = state;
    scan_idx_next  = scan_idx;
    count_next     = count;
    feed_next.valid = (state == S_SCAN);
    feed_next.first = (scan_idx == '0);
    feed_next.idx   = scan_idx;
    value_next     = '0;
    source_next    = '0;
    status_next    = kwm_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!is_pop) begin
            if (full) begin
              status_next = kwm_pkg::ST_FULL;
            end else begin
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            status_next = kwm_pkg::ST_EMPTY;
          end else begin
            scan_idx_next = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        scan_idx_next = scan_idx + 1'b1;
        if (scan_idx == last_idx) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        value_next  = kwm_pkg::value_to_field(best_entry.value);
        source_next = best_entry.tag;
        if (slot_free) begin
          count_next = count_m1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  assign occ_wide = {{kwm_pkg::OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      feed      <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      feed     <= feed_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= value_next;
      out_source <= source_next;
      status     <= status_next;
      not_empty  <= (count_next != '0);
      occupancy  <= occ_wide[kwm_pkg::OCC_W-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kwm_pkg::FULL_COUNT)
    else $error("entry count exceeds the store depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop && !full) |=> (count == $past(count) + 1'b1))
    else $error("accepted insert did not add an entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    finish |=> (count == $past(count_m1)) && res_valid && (status == kwm_pkg::ST_OK))
    else $error("completed pop did not remove exactly one entry");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0) && (scan_idx <= last_idx))
    else $error("scan read beyond the held entries");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop && full) |=> (count == $past(count)) && (status == kwm_pkg::ST_FULL))
    else $error("insert into a full store was not dropped");
`endif

endmodule

FILE: dv/kway_merge_min_heap_core_tb.sv
// Self-checking testbench for kway_merge_min_heap_core: directed and random insert/pop words,
// checked against an in-bench min-queue predictor. Depends on kwm_pkg and the core RTL.
`timescale 1ns / 1ps

module kway_merge_min_heap_core_tb;

  localparam int CLK_HALF      = 2;
  localparam int NUM_RANDOM    = 400;
  localparam int IDLE_PCT      = 6;
  localparam int HOLD_OFF      = 60;
  localparam int HOLD_AT       = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic                command;
    logic [2:0]          src;
    logic signed [31:0]  val;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0]  value;
    logic [2:0]          source;
    logic [1:0]          status;
    logic                not_empty;
    logic [3:0]          occupancy;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic command = kwm_pkg::CMD_INSERT;
  logic [2:0] source_id = '0;
  logic signed [31:0] value = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic signed [31:0] out_value;
  logic [2:0] out_source;
  logic [1:0] status;
  logic not_empty;
  logic [3:0] occupancy;

  cmd_word_t    cmd_words[$];
  result_word_t heap_results_due[$];
  cmd_word_t    next_word;
  result_word_t exp_word;
  result_word_t got_word;

  logic signed [31:0] heap_val[kwm_pkg::NUM_SOURCES];
  logic [2:0]         heap_tag[kwm_pkg::NUM_SOURCES];
  int heap_count = 0;

  int words_offered = 0;
  int words_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;
  int gen_count = 0;
  int total_words = 0;
  logic signed [31:0] stream_head[8];

  kway_merge_min_heap_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .command    (command),
    .source_id  (source_id),
    .value      (value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_value  (out_value),
    .out_source (out_source),
    .status     (status),
    .not_empty  (not_empty),
    .occupancy  (occupancy)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic predict_heap_result(input cmd_word_t w);
    result_word_t r;
    int best;
    r = '0;
    r.status = kwm_pkg::ST_OK;
    if (w.command == kwm_pkg::CMD_INSERT) begin
      if (heap_count >= kwm_pkg::NUM_SOURCES) begin
        r.status = kwm_pkg::ST_FULL;
      end else begin
        heap_val[heap_count] = w.val;
        heap_tag[heap_count] = w.src;
        heap_count++;
      end
    end else if (heap_count == 0) begin
      r.status = kwm_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < heap_count; i++) begin
        if (heap_val[i] < heap_val[best] ||
            (heap_val[i] == heap_val[best] && heap_tag[i] < heap_tag[best])) begin
          best = i;
        end
      end
      r.value = heap_val[best];
      r.source = heap_tag[best];
      heap_count--;
      heap_val[best] = heap_val[heap_count];
      heap_tag[best] = heap_tag[heap_count];
    end
    r.not_empty = (heap_count != 0);
    r.occupancy = 4'(heap_count);
    heap_results_due.push_back(r);
  endtask

  task automatic queue_word(input logic cmd, input logic [2:0] src, input logic [31:0] val);
    cmd_words.push_back(cmd_word_t'{cmd, src, val});
    if (cmd == kwm_pkg::CMD_INSERT && gen_count < kwm_pkg::NUM_SOURCES) begin
      gen_count++;
    end else if (cmd == kwm_pkg::CMD_POP && gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic logic [31:0] pick_value(input logic [2:0] src);
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = 32'(int'($urandom_range(6)) - 3);
      6: begin
        case ($urandom_range(3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: begin
        stream_head[src] = stream_head[src] + 32'($urandom_range(3));
        v = stream_head[src];
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [2:0] src;
    int insert_pct;
    for (int s = 0; s < 8; s++) begin
      stream_head[s] = -32'sd20 + 32'(s);
    end

    queue_word(kwm_pkg::CMD_POP, 3'd0, 32'h0);
    queue_word(kwm_pkg::CMD_INSERT, 3'd7, 32'h7fff_ffff);
    queue_word(kwm_pkg::CMD_INSERT, 3'd7, 32'h8000_0000);
    queue_word(kwm_pkg::CMD_INSERT, 3'd0, 32'h8000_0000);
    queue_word(kwm_pkg::CMD_INSERT, 3'd3, 32'h0);
    queue_word(kwm_pkg::CMD_INSERT, 3'd5, 32'hffff_ffff);
    queue_word(kwm_pkg::CMD_INSERT, 3'd6, 32'd5);
    queue_word(kwm_pkg::CMD_INSERT, 3'd4, 32'd5);
    queue_word(kwm_pkg::CMD_INSERT, 3'd2, 32'd5);
    queue_word(kwm_pkg::CMD_INSERT, 3'd1, 32'h5555_5555);
    queue_word(kwm_pkg::CMD_INSERT, 3'd0, 32'haaaa_aaaa);
    for (int i = 0; i < 9; i++) begin
      queue_word(kwm_pkg::CMD_POP, 3'(i), $urandom);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ((i / 40) % 3)
        0: insert_pct = 75;
        1: insert_pct = 25;
        default: insert_pct = 50;
      endcase
      src = 3'($urandom_range(7));
      if ($urandom_range(99) < insert_pct) begin
        queue_word(kwm_pkg::CMD_INSERT, src, pick_value(src));
      end else begin
        queue_word(kwm_pkg::CMD_POP, src, $urandom);
      end
    end
    total_words = cmd_words.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken < total_words || heap_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (words_offered == words_taken) begin
      if (cmd_words.size() != 0 &&
          ((words_offered >= 150 && words_offered < 250) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_word = cmd_words.pop_front();
        cmd_valid <= 1'b1;
        command <= next_word.command;
        source_id <= next_word.src;
        value <= next_word.val;
        words_offered++;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      res_ready <= 1'b0;
      hold_left = HOLD_OFF - 1;
      hold_done = 1'b1;
    end else if (results_seen >= 150 && results_seen < 250) begin
      res_ready <= 1'b1;
    end else begin
      res_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) begin
      predict_heap_result(cmd_word_t'{command, source_id, value});
      words_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      got_word = result_word_t'{out_value, out_source, status, not_empty, occupancy};
      if (heap_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result word with none expected: value=%0d source=%0d status=%0d",
                   got_word.value, got_word.source, got_word.status);
        end
      end else begin
        exp_word = heap_results_due.pop_front();
        if (got_word.value != exp_word.value || got_word.source != exp_word.source ||
            got_word.status != exp_word.status || got_word.not_empty != exp_word.not_empty ||
            got_word.occupancy != exp_word.occupancy) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("word %0d mismatch: exp value=%0d source=%0d status=%0d ne=%0d occ=%0d",
                     results_seen, exp_word.value, exp_word.source, exp_word.status,
                     exp_word.not_empty, exp_word.occupancy);
            $display("                  got value=%0d source=%0d status=%0d ne=%0d occ=%0d",
                     got_word.value, got_word.source, got_word.status,
                     got_word.not_empty, got_word.occupancy);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ram.sv
hw/rtl/kwm_minscan.sv
hw/rtl/kway_merge_min_heap_core.sv
dv/kway_merge_min_heap_core_tb.sv
